// ===== design/inductive_steering_pd_assert.svh =====
// assertion macros for the inductive steering controller
`ifndef INDUCTIVE_STEERING_PD_ASSERT_SVH
`define INDUCTIVE_STEERING_PD_ASSERT_SVH

// same-cycle implication
`define ISP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/isp_pkg.sv =====
// shared types and constants for the inductive steering controller
`timescale 1ns / 1ps
package isp_pkg;

    localparam int ADC_BITS = 12;
    localparam int CMD_W    = 2;
    localparam int PROP_W   = 8;
    localparam int KD_W     = 10;
    localparam int ERR_W    = 8;
    localparam int ANGLE_W  = 15;
    localparam int DEN_W    = ADC_BITS + 1;
    localparam int PD_W     = 21;

    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NORMAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd2;

    localparam logic REG_PROP_GAIN  = 1'b0;
    localparam logic REG_DERIV_GAIN = 1'b1;

    localparam logic [PROP_W-1:0] PROP_GAIN_RESET  = 8'd15;
    localparam logic [KD_W-1:0]   DERIV_GAIN_RESET = 10'd230;

    // serial divider
    localparam int DIV_W  = 20;
    localparam int QUO_W  = 12;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ERR_STEPS   = 4'd7;
    localparam logic [STEP_W-1:0] ANGLE_STEPS = 4'd12;
    // 100 scaled by 2^12 so that twelve quotient bits give floor(x / 100)
    localparam logic [DIV_W-1:0] ANGLE_DIVISOR = 20'd409600;

    // serial multiplier
    localparam int MCAND_W = 19;
    localparam int PROD_W  = MCAND_W + KD_W;
    localparam logic [STEP_W-1:0] MUL_STEPS = 4'd10;
    // smallest product whose quotient by 100 exceeds the 15 degree swing
    localparam logic [PROD_W-1:0] CLAMP_LIMIT = 29'd384100;

    localparam logic [ANGLE_W-1:0] ANGLE_CENTER = 15'd23040;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN    = 15'd19200;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 15'd26880;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [MCAND_W-1:0] mcand;
        logic [KD_W-1:0]    mplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic [PROP_W-1:0] prop_gain;
        logic [KD_W-1:0]   deriv_gain_q8;
    } gains_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_q8;
        logic               clamped;
        logic [ERR_W-1:0]   track_error;
    } result_t;

endpackage

// ===== design/isp_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module isp_div (
    input  logic             clk,
    input  logic             rst_n,
    input  isp_pkg::div_req_t req,
    output isp_pkg::div_rsp_t rsp
);
    import isp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [DIV_W-1:0]  rem_shift;
    logic              take;

    assign rem_shift = {rem_reg[DIV_W-2:0], 1'b0};
    assign take      = (rem_shift >= den_reg);
    assign rem_next  = take ? (rem_shift - den_reg) : rem_shift;
    assign quo_next  = {quo_reg[QUO_W-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != STEP_W'(1));
            done_reg <= (cnt_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== design/isp_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module isp_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  isp_pkg::mul_req_t req,
    output isp_pkg::mul_rsp_t rsp
);
    import isp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [KD_W-1:0]   mplier_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = mplier_reg[0] ? (prod_reg + mcand_reg) : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != STEP_W'(1));
            done_reg <= (cnt_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg  <= PROD_W'(req.mcand);
            mplier_reg <= req.mplier;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[KD_W-1:1]};
            prod_reg   <= prod_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

endmodule

// ===== design/isp_ctrl.sv =====
// sequencer: error division, pd multiplies, angle division and saturation
`timescale 1ns / 1ps
module isp_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [isp_pkg::CMD_W-1:0]       command,
    input  logic [isp_pkg::ADC_BITS-1:0]    adc_left,
    input  logic [isp_pkg::ADC_BITS-1:0]    adc_right,
    input  logic [isp_pkg::ADC_BITS-1:0]    adc_left_outer,
    input  logic [isp_pkg::ADC_BITS-1:0]    adc_right_outer,
    input  isp_pkg::gains_t                 gains,
    input  logic                            out_free,
    output logic                            res_valid,
    output isp_pkg::result_t                res,
    output isp_pkg::div_req_t               div_req,
    input  isp_pkg::div_rsp_t               div_rsp,
    output isp_pkg::mul_req_t               mul_req,
    input  isp_pkg::mul_rsp_t               mul_rsp
);
    import isp_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ERR_DIV   = 3'd1;
    localparam logic [2:0] S_DERIV_MUL = 3'd2;
    localparam logic [2:0] S_GAIN_MUL  = 3'd3;
    localparam logic [2:0] S_ANGLE_DIV = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [ERR_W-1:0] prev_err_reg;
    logic [ERR_W-1:0] prev_err_next;
    logic [ERR_W-1:0] err_reg;
    logic [ERR_W-1:0] err_next;
    logic             err_neg_reg;
    logic             err_neg_next;
    logic             diff_neg_reg;
    logic             diff_neg_next;
    logic             sum_neg_reg;
    logic             sum_neg_next;
    result_t          res_reg;
    result_t          res_next;

    logic [ADC_BITS-1:0] sel_a;
    logic [ADC_BITS-1:0] sel_b;
    logic                a_ge_b;
    logic [ADC_BITS-1:0] mag;
    logic [DEN_W-1:0]    den_in;
    logic                take_item;
    logic [ERR_W-1:0]    err_q;
    logic [ERR_W-1:0]    err_new;
    logic [ERR_W:0]      diff;
    logic [ERR_W:0]      diff_mag;
    logic [PD_W-1:0]     err_scaled;
    logic [PD_W-1:0]     deriv_term;
    logic [PD_W-1:0]     sum;
    logic [PD_W-1:0]     sum_mag;
    logic                over;
    logic [ANGLE_W-1:0]  quo_ext;

    assign sel_a  = (command == CMD_CIRCLE) ? adc_left_outer  : adc_left;
    assign sel_b  = (command == CMD_CIRCLE) ? adc_right_outer : adc_right;
    assign a_ge_b = (sel_a >= sel_b);
    assign mag    = a_ge_b ? (sel_a - sel_b) : (sel_b - sel_a);
    assign den_in = DEN_W'(sel_a) + DEN_W'(sel_b) + DEN_W'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign take_item = in_valid && in_ready
                       && ((command == CMD_NORMAL) || (command == CMD_CIRCLE));

    assign err_q    = div_rsp.quo[ERR_W-1:0];
    assign err_new  = err_neg_reg ? (ERR_W'(0) - err_q) : err_q;
    assign diff     = {err_new[ERR_W-1], err_new} - {prev_err_reg[ERR_W-1], prev_err_reg};
    assign diff_mag = diff[ERR_W] ? ((ERR_W+1)'(0) - diff) : diff;

    assign err_scaled = {{(PD_W-ERR_W-8){err_reg[ERR_W-1]}}, err_reg, 8'b0};
    assign deriv_term = PD_W'(mul_rsp.prod[MCAND_W-1:0]);
    assign sum        = diff_neg_reg ? (err_scaled - deriv_term) : (err_scaled + deriv_term);
    assign sum_mag    = sum[PD_W-1] ? (PD_W'(0) - sum) : sum;

    assign over    = (mul_rsp.prod >= CLAMP_LIMIT);
    assign quo_ext = ANGLE_W'(div_rsp.quo);

    always_comb
    begin
        state_next    = state_reg;
        prev_err_next = prev_err_reg;
        err_next      = err_reg;
        err_neg_next  = err_neg_reg;
        diff_neg_next = diff_neg_reg;
        sum_neg_next  = sum_neg_reg;
        res_next      = res_reg;
        div_req       = '0;
        mul_req       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take_item)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'(mag);
                    div_req.den   = DIV_W'(den_in);
                    div_req.steps = ERR_STEPS;
                    err_neg_next  = !a_ge_b;
                    state_next    = S_ERR_DIV;
                end
            end
            S_ERR_DIV:
            begin
                if (div_rsp.done)
                begin
                    err_next       = err_new;
                    prev_err_next  = err_new;
                    diff_neg_next  = diff[ERR_W];
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MCAND_W'(diff_mag);
                    mul_req.mplier = gains.deriv_gain_q8;
                    state_next     = S_DERIV_MUL;
                end
            end
            S_DERIV_MUL:
            begin
                if (mul_rsp.done)
                begin
                    sum_neg_next   = sum[PD_W-1];
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = sum_mag[MCAND_W-1:0];
                    mul_req.mplier = KD_W'(gains.prop_gain);
                    state_next     = S_GAIN_MUL;
                end
            end
            S_GAIN_MUL:
            begin
                if (mul_rsp.done)
                begin
                    res_next.track_error = err_reg;
                    if (over)
                    begin
                        res_next.angle_q8 = sum_neg_reg ? ANGLE_MIN : ANGLE_MAX;
                        res_next.clamped  = 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = mul_rsp.prod[DIV_W-1:0];
                        div_req.den   = ANGLE_DIVISOR;
                        div_req.steps = ANGLE_STEPS;
                        state_next    = S_ANGLE_DIV;
                    end
                end
            end
            S_ANGLE_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next.angle_q8 = sum_neg_reg ? (ANGLE_CENTER - quo_ext)
                                                    : (ANGLE_CENTER + quo_ext);
                    res_next.clamped  = 1'b0;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            prev_err_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        err_neg_reg  <= err_neg_next;
        diff_neg_reg <= diff_neg_next;
        sum_neg_reg  <= sum_neg_next;
        res_reg      <= res_next;
    end

    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== design/inductive_steering_pd.sv =====
// a new request is taken only when idle, once the last result has passed to the
// output register; a stop request is accepted without starting any work
// the work runs on the shared bit-serial divider (7 and 12 steps) and
// the shift-add multiplier (two passes of 10 steps); a saturated angle skips the angle division
// reset: gains return to 15 and 230, previous error to zero, no result pending
`timescale 1ns / 1ps
module inductive_steering_pd (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [isp_pkg::CMD_W-1:0]    command,
    input  logic [isp_pkg::ADC_BITS-1:0] adc_left,
    input  logic [isp_pkg::ADC_BITS-1:0] adc_right,
    input  logic [isp_pkg::ADC_BITS-1:0] adc_left_outer,
    input  logic [isp_pkg::ADC_BITS-1:0] adc_right_outer,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [isp_pkg::ANGLE_W-1:0]  angle_q8,
    output logic                         clamped,
    output logic signed [isp_pkg::ERR_W-1:0] track_error
);
    import isp_pkg::*;

    `include "inductive_steering_pd_assert.svh"

    gains_t    gains_reg;
    logic      cfg_write;
    logic      out_valid_reg;
    result_t   out_res_reg;
    logic      out_free;
    logic      res_valid;
    result_t   res;
    logic      load;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DERIV_GAIN) ? 32'(gains_reg.deriv_gain_q8)
                                                    : 32'(gains_reg.prop_gain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain     <= PROP_GAIN_RESET;
            gains_reg.deriv_gain_q8 <= DERIV_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_PROP_GAIN)
            begin
                gains_reg.prop_gain <= pwdata[PROP_W-1:0];
            end
            else
            begin
                gains_reg.deriv_gain_q8 <= pwdata[KD_W-1:0];
            end
        end
    end

    isp_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .adc_left        (adc_left),
        .adc_right       (adc_right),
        .adc_left_outer  (adc_left_outer),
        .adc_right_outer (adc_right_outer),
        .gains           (gains_reg),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .mul_req         (mul_req),
        .mul_rsp         (mul_rsp)
    );

    isp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    isp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;
    assign load     = res_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign angle_q8    = out_res_reg.angle_q8;
    assign clamped     = out_res_reg.clamped;
    assign track_error = out_res_reg.track_error;

    `ISP_ASSERT_NOW(a_angle_range, out_valid_reg, (angle_q8 >= ANGLE_MIN) && (angle_q8 <= ANGLE_MAX), "angle out of range")
    `ISP_ASSERT_NOW(a_clamp_on_limit, out_valid_reg && clamped, (angle_q8 == ANGLE_MIN) || (angle_q8 == ANGLE_MAX), "clamped angle not on a limit")
    `ISP_ASSERT_NOW(a_error_range, out_valid_reg, track_error != 8'sh80, "track error outside -127..127")
    `ISP_ASSERT_NEXT(a_stop_no_work, in_valid && in_ready && (command != CMD_NORMAL) && (command != CMD_CIRCLE), in_ready, "stop request started work")

endmodule
